// ===== rtl/rva_pkg.sv =====
// Package for the axis-angle vector rotation unit.
// Holds the item and rotator state types, pipeline constants and the
// arctangent table; used by every module in rtl/.
package rva_pkg;

    // Rotator depth, capped at the length of the arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_CELLS  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                  : CORDIC_STAGES;

    // Gain-compensated start value of x, Q2.30
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    // Rotator working width (Q2.30 with headroom) and stage index width
    localparam int CW = 34;
    localparam int IW = 5;

    // One input item as carried along the pipeline
    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } item_t;

    // Rotator state handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cord_t;

    // One result item
    typedef struct packed {
        logic signed [31:0] rot_z;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_x;
    } result_t;

    // Arctangent of 2^-idx, 2^32 = one turn
    function automatic logic [29:0] atan_turns(input logic [IW-1:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd536870912;
            5'd1:    val = 30'd316933406;
            5'd2:    val = 30'd167458907;
            5'd3:    val = 30'd85004756;
            5'd4:    val = 30'd42667331;
            5'd5:    val = 30'd21354465;
            5'd6:    val = 30'd10680862;
            5'd7:    val = 30'd5340245;
            5'd8:    val = 30'd2670163;
            5'd9:    val = 30'd1335087;
            5'd10:   val = 30'd667544;
            5'd11:   val = 30'd333772;
            5'd12:   val = 30'd166886;
            5'd13:   val = 30'd83443;
            5'd14:   val = 30'd41722;
            5'd15:   val = 30'd20861;
            5'd16:   val = 30'd10430;
            5'd17:   val = 30'd5215;
            5'd18:   val = 30'd2608;
            5'd19:   val = 30'd1304;
            5'd20:   val = 30'd652;
            5'd21:   val = 30'd326;
            5'd22:   val = 30'd163;
            5'd23:   val = 30'd81;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/rva_cordic_cell.sv =====
// One rotation cell of the sine/cosine chain.
// Depends on rva_pkg for the state types and the arctangent table.
module rva_cordic_cell import rva_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [IW-1:0] stage_idx,
    input  logic          in_valid,
    input  cord_t         cord_in,
    input  item_t         item_in,
    output logic          out_valid,
    output cord_t         cord_out,
    output item_t         item_out
);

    logic                 out_valid_reg;
    cord_t                cord_reg, cord_next;
    item_t                item_reg;
    logic signed [CW-1:0] x, y, z, dx, dy, at;

    // Rotate toward zero residual angle by one micro-step
    always_comb begin
        x  = cord_in.x;
        y  = cord_in.y;
        z  = cord_in.z;
        dx = y >>> stage_idx;
        dy = x >>> stage_idx;
        at = $signed({{(CW-30){1'b0}}, atan_turns(stage_idx)});
        cord_next.flip = cord_in.flip;
        if (z >= 0) begin
            cord_next.x = x - dx;
            cord_next.y = y + dy;
            cord_next.z = z - at;
        end else begin
            cord_next.x = x + dx;
            cord_next.y = y - dy;
            cord_next.z = z + at;
        end
    end

    // Advance when the pipeline is not frozen
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid;
            cord_reg      <= cord_next;
            item_reg      <= item_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign cord_out  = cord_reg;
    assign item_out  = item_reg;

endmodule

// ===== rtl/rva_transform.sv =====
// Builds the rotation matrix from cos/sin and the axis, then applies it.
// Six register stages; depends on rva_pkg.
module rva_transform import rva_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  cord_t   cord_in,
    input  item_t   item_in,
    output logic    out_valid,
    output result_t result
);

    logic [5:0] valid_reg;

    // Stage 1: signed cos/sin, 1-cos, cos term, axis products
    logic signed [CW-1:0] c1_next, s1_next, s_reg, c28_reg;
    logic signed [CW:0]   omc_reg;
    logic signed [31:0]   pp_reg [3][3];
    logic signed [15:0]   ax1 [3];
    item_t                it1_reg;

    // Stage 2: outer and cross products
    logic signed [66:0]   op_reg [3][3];
    logic signed [49:0]   ks_reg [3];
    logic signed [CW-1:0] c28_2_reg;
    item_t                it2_reg;
    logic signed [15:0]   ax2 [3];

    // Stage 3: rounded terms
    logic signed [36:0]   outer_reg [3][3];
    logic signed [33:0]   u_reg [3];
    logic signed [CW-1:0] c28_3_reg;
    item_t                it3_reg;

    // Stage 4: saturated entries
    logic signed [31:0]   m_reg [3][3];
    logic signed [37:0]   e_next [3][3];
    item_t                it4_reg;

    // Stage 5: entry times component
    logic signed [63:0]   pr_reg [3][3];
    logic signed [31:0]   v4 [3];

    // Stage 6: row sums, rounding, saturation
    result_t              res_reg;
    logic signed [65:0]   sum [3];
    logic signed [37:0]   r [3];
    logic signed [31:0]   rc [3];

    always_comb begin
        c1_next = cord_in.flip ? -cord_in.x : cord_in.x;
        s1_next = cord_in.flip ? -cord_in.y : cord_in.y;
        ax1[0] = item_in.axis_x;
        ax1[1] = item_in.axis_y;
        ax1[2] = item_in.axis_z;
        ax2[0] = it1_reg.axis_x;
        ax2[1] = it1_reg.axis_y;
        ax2[2] = it1_reg.axis_z;
        v4[0]  = it4_reg.vec_x;
        v4[1]  = it4_reg.vec_y;
        v4[2]  = it4_reg.vec_z;
    end

    // Combine outer, diagonal and cross terms
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i == j)
                    e_next[i][j] = 38'(outer_reg[i][j]) + 38'(c28_3_reg);
                else if (j == (i + 2) % 3)
                    e_next[i][j] = 38'(outer_reg[i][j]) + 38'(u_reg[3 - i - j]);
                else
                    e_next[i][j] = 38'(outer_reg[i][j]) - 38'(u_reg[3 - i - j]);
            end
        end
    end

    // Sum rows, round to Q16.16 and saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = 66'(pr_reg[i][0]) + 66'(pr_reg[i][1]) + 66'(pr_reg[i][2]);
            r[i]   = 38'((sum[i] + 66'sd134217728) >>> 28);
            if (r[i] > 38'sd2147483647)
                rc[i] = 32'sh7fffffff;
            else if (r[i] < -38'sd2147483648)
                rc[i] = 32'sh80000000;
            else
                rc[i] = 32'(r[i]);
        end
    end

    // Valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg   <= s1_next;
            omc_reg <= (CW+1)'(35'sd1073741824) - (CW+1)'(c1_next);
            c28_reg <= (c1_next + 34'sd2) >>> 2;
            it1_reg <= item_in;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    pp_reg[i][j] <= 32'(ax1[i]) * 32'(ax1[j]);

            for (int i = 0; i < 3; i++) begin
                ks_reg[i] <= 50'(ax2[i]) * 50'(s_reg);
                for (int j = 0; j < 3; j++)
                    op_reg[i][j] <= 67'(omc_reg) * 67'(pp_reg[i][j]);
            end
            c28_2_reg <= c28_reg;
            it2_reg   <= it1_reg;

            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= 34'((ks_reg[i] + 50'sd32768) >>> 16);
                for (int j = 0; j < 3; j++)
                    outer_reg[i][j] <= 37'((op_reg[i][j] + 67'sd536870912) >>> 30);
            end
            c28_3_reg <= c28_2_reg;
            it3_reg   <= it2_reg;

            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (e_next[i][j] > 38'sd1073741824)
                        m_reg[i][j] <= 32'sd1073741824;
                    else if (e_next[i][j] < -38'sd1073741824)
                        m_reg[i][j] <= -32'sd1073741824;
                    else
                        m_reg[i][j] <= 32'(e_next[i][j]);
            it4_reg <= it3_reg;

            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    pr_reg[i][j] <= 64'(m_reg[i][j]) * 64'(v4[j]);

            res_reg.rot_x <= rc[0];
            res_reg.rot_y <= rc[1];
            res_reg.rot_z <= rc[2];
        end
    end

    assign out_valid = valid_reg[5];
    assign result    = res_reg;

endmodule

// ===== rtl/rotate_vector_axis_angle_unit.sv =====
// Axis-angle (Rodrigues) rotation of a Q16.16 vector, stream in and out.
// Channels: s_axis takes the vector, a Q1.14 axis and a 16-bit binary angle
// in one transaction; m_axis returns the rotated vector, saturated.
// One result per input transaction, in order.
// Throughput: one transaction per cycle while the skid register is empty;
// every unit is fully pipelined. Path to m_tvalid: the accepting edge loads
// the first cell, then the remaining cells, six matrix stages and the
// output register follow.
// When m_tready is low the output register holds and one more result lands
// in the skid register; the pipeline then freezes and s_tready drops until
// the skid register drains. s_tready never depends on m_tready in the same
// cycle.
// Reset (aresetn low, synchronous) empties the pipeline and both output
// registers; the block holds no other state.
// Depends on rva_pkg, rva_cordic_cell and rva_transform.
module rotate_vector_axis_angle_unit import rva_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_x, rot_y, rot_z
    output logic [95:0]  m_tdata
);

    logic    en;
    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    item_t   item0;
    cord_t   cord0;
    logic [15:0] turn;
    logic        flip;
    logic [31:0] ang;

    cord_t chain_c [CORDIC_CELLS+1];
    item_t chain_i [CORDIC_CELLS+1];
    logic  chain_v [CORDIC_CELLS+1];

    logic    p_valid;
    result_t p_data;

    // Unpack the transaction and seed the rotator
    always_comb begin
        item0.vec_x  = s_tdata[31:0];
        item0.vec_y  = s_tdata[63:32];
        item0.vec_z  = s_tdata[95:64];
        item0.axis_x = s_tdata[111:96];
        item0.axis_y = s_tdata[127:112];
        item0.axis_z = s_tdata[143:128];
        turn         = s_tdata[159:144];
        flip         = turn[15] ^ turn[14];
        ang          = {turn[15] ^ flip, turn[14:0], 16'h0000};
        cord0.x      = CORDIC_START;
        cord0.y      = '0;
        cord0.z      = CW'($signed(ang));
        cord0.flip   = flip;
    end

    assign en         = !skid_valid_reg;
    assign s_tready   = en;
    assign chain_c[0] = cord0;
    assign chain_i[0] = item0;
    assign chain_v[0] = s_tvalid;

    // Chain of rotation cells
    for (genvar g = 0; g < CORDIC_CELLS; g++) begin : g_cell
        rva_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_idx (IW'(g)),
            .in_valid  (chain_v[g]),
            .cord_in   (chain_c[g]),
            .item_in   (chain_i[g]),
            .out_valid (chain_v[g+1]),
            .cord_out  (chain_c[g+1]),
            .item_out  (chain_i[g+1])
        );
    end

    rva_transform u_transform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_v[CORDIC_CELLS]),
        .cord_in   (chain_c[CORDIC_CELLS]),
        .item_in   (chain_i[CORDIC_CELLS]),
        .out_valid (p_valid),
        .result    (p_data)
    );

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (en && p_valid) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= p_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            out_data_reg   <= skid_data_reg;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= p_valid;
            out_data_reg   <= p_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.rot_z, out_data_reg.rot_y, out_data_reg.rot_x};

    // Skid register is only occupied behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    // Skid register fills only while the output is stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    // A taken output frees the skid register in the next cycle
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg)
        else $error("skid did not drain after output transaction");

endmodule
